/* hdl/vertex_grid_bilinear_resample_defines.svh */
// Assertion macros for the bilinear resample block.
`ifndef VERTEX_GRID_BILINEAR_RESAMPLE_DEFINES_SVH
`define VERTEX_GRID_BILINEAR_RESAMPLE_DEFINES_SVH
`ifndef SYNTHESIS
`define VGBR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("vgbr assertion failed");
`define VGBR_ASSERT_ALWAYS(label, clk, rst_n, expr) \
label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
	else $error("vgbr invariant failed");
`else
`define VGBR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define VGBR_ASSERT_ALWAYS(label, clk, rst_n, expr)
`endif
`endif

/* hdl/vgbr_pkg.sv */
package vgbr_pkg;

	localparam int MAX_SIDE    = 64;
	localparam int WEIGHT_BITS = 16;

	localparam int SIDE_W     = $clog2(MAX_SIDE);
	localparam int CFG_W      = SIDE_W + 1;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;
	localparam int N_W        = 2 * SIDE_W;
	localparam int DIV_W      = N_W + WEIGHT_BITS;
	localparam int DIV_STEPS  = 4;
	localparam int DIV_STAGES = (DIV_W + DIV_STEPS - 1) / DIV_STEPS;
	localparam int PAD_W      = DIV_STAGES * DIV_STEPS;
	localparam int Q_W        = PAD_W - WEIGHT_BITS;
	localparam int WGT_W      = WEIGHT_BITS + 1;
	localparam int AX_LAT     = DIV_STAGES + 2;
	localparam int RESULT_LAT = AX_LAT + 5;

	localparam int NUM_BANKS  = 4;
	localparam int BANK_AW    = 2 * (SIDE_W - 1);
	localparam int BANK_DEPTH = 1 << BANK_AW;

	localparam int COORD_W = 32;
	localparam int VTX_W   = 2 * COORD_W;
	localparam int D_W     = COORD_W + 1;
	localparam int D11_W   = COORD_W + 2;
	localparam int WS_W    = WGT_W + 1;
	localparam int P1_W    = WS_W + D_W;
	localparam int P11_W   = WS_W + D11_W;
	localparam int T_W     = P11_W - WEIGHT_BITS;
	localparam int PQ_W    = WS_W + T_W;

	localparam logic [CFG_IDX_W-1:0] CFG_SRC_COLS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_ROWS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TGT_COLS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TGT_ROWS = 2'd3;

	localparam logic OP_WRITE   = 1'b0;
	localparam logic OP_REQUEST = 1'b1;

	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_OUTSIDE = 1'b1;

	typedef logic [SIDE_W-1:0] side_idx_t;
	typedef logic [CFG_W-1:0]  side_cnt_t;

	typedef struct packed {
		side_idx_t        idx;
		logic [WGT_W-1:0] weight;
	} axis_t;

	typedef struct packed {
		logic                op;
		logic                wr_ok;
		logic                oob;
		side_idx_t           col;
		side_idx_t           row;
		logic [COORD_W-1:0]  x;
		logic [COORD_W-1:0]  y;
	} ctl_t;

endpackage

/* hdl/vgbr_ram.sv */
module vgbr_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hdl/vgbr_axis.sv */
module vgbr_axis import vgbr_pkg::*; (
	input  logic      clk,
	input  side_idx_t pos,
	input  side_cnt_t src,
	input  side_cnt_t tgt,
	output axis_t     res
);

	logic [SIDE_W-1:0] div_d;
	logic [SIDE_W-1:0] src_m1;
	logic [N_W-1:0]    prod;

	logic [PAD_W-1:0]  num_s [0:DIV_STAGES];
	logic [SIDE_W-1:0] rem_s [0:DIV_STAGES];
	logic [PAD_W-1:0]  step_num [0:DIV_STAGES-1];
	logic [SIDE_W-1:0] step_rem [0:DIV_STAGES-1];

	logic [Q_W-1:0] quo;

	assign div_d  = SIDE_W'(tgt - 1'b1);
	assign src_m1 = SIDE_W'(src - 1'b1);
	assign prod   = N_W'(pos) * N_W'(src_m1);

	// num holds the unused dividend bits on top and shifts quotient bits in below
	always_ff @(posedge clk) begin
		num_s[0] <= PAD_W'({prod, {WEIGHT_BITS{1'b0}}});
		rem_s[0] <= '0;
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		always_comb begin : step
			logic [SIDE_W:0]   r2;
			logic [SIDE_W-1:0] r;
			logic [PAD_W-1:0]  n;
			r  = rem_s[k];
			n  = num_s[k];
			r2 = '0;
			for (int j = 0; j < DIV_STEPS; j++) begin
				r2 = {r, n[PAD_W-1]};
				n  = {n[PAD_W-2:0], 1'b0};
				if (r2 >= {1'b0, div_d}) begin
					r2   = r2 - {1'b0, div_d};
					n[0] = 1'b1;
				end
				r = r2[SIDE_W-1:0];
			end
			step_num[k] = n;
			step_rem[k] = r;
		end

		always_ff @(posedge clk) begin
			num_s[k+1] <= step_num[k];
			rem_s[k+1] <= step_rem[k];
		end
	end

	assign quo = num_s[DIV_STAGES][PAD_W-1:WEIGHT_BITS];

	// clamp to the last cell with full weight
	always_ff @(posedge clk) begin
		if (quo >= Q_W'(src_m1)) begin
			res.idx    <= SIDE_W'(src - 2'd2);
			res.weight <= WGT_W'(1) << WEIGHT_BITS;
		end else begin
			res.idx    <= quo[SIDE_W-1:0];
			res.weight <= {1'b0, num_s[DIV_STAGES][WEIGHT_BITS-1:0]};
		end
	end

endmodule

/* hdl/vertex_grid_bilinear_resample.sv */
// Result: an accepted request gives its result with done high for one cycle, after
// the registered axis divider stages, the bank read and the blend stages.
// Throughput: one item per cycle; busy stays low, config writes complete at once.
// Writes travel the same pipeline as requests and reach the banks in order.
// Reset clears control and sets all four sizes to 2; vertex banks hold no reset.
`include "vertex_grid_bilinear_resample_defines.svh"
module vertex_grid_bilinear_resample import vgbr_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        opcode,
	input  logic [SIDE_W-1:0]           grid_column,
	input  logic [SIDE_W-1:0]           grid_row,
	input  logic signed [COORD_W-1:0]   vertex_x,
	input  logic signed [COORD_W-1:0]   vertex_y,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data,
	output logic                        done,
	output logic [SIDE_W-1:0]           out_column,
	output logic [SIDE_W-1:0]           out_row,
	output logic signed [COORD_W-1:0]   out_x,
	output logic signed [COORD_W-1:0]   out_y,
	output logic                        status
);

	localparam int LA = AX_LAT - 1;

	function automatic side_cnt_t clamp_side(input logic [CFG_DATA_W-1:0] v);
		side_cnt_t w;
		w = CFG_W'(v);
		if (w < CFG_W'(2)) begin
			return CFG_W'(2);
		end
		if (w > CFG_W'(MAX_SIDE)) begin
			return CFG_W'(MAX_SIDE);
		end
		return w;
	endfunction

	side_cnt_t src_cols_q, src_rows_q, tgt_cols_q, tgt_rows_q;
	logic      accept;
	ctl_t      in_ctl;
	logic      ctl_v_s [0:LA];
	ctl_t      ctl_s   [0:LA];
	axis_t     ax_col, ax_row;

	logic                 wr_issue, rd_issue;
	logic [NUM_BANKS-1:0] bank_we;
	logic [BANK_AW-1:0]   bank_waddr;
	logic [VTX_W-1:0]     bank_wdata;
	logic [BANK_AW-1:0]   bank_raddr [0:NUM_BANKS-1];
	logic [VTX_W-1:0]     bank_rdata [0:NUM_BANKS-1];

	logic             req_v_s9, oob_s9, px_s9, py_s9;
	side_idx_t        col_s9, row_s9;
	logic [WGT_W-1:0] fx_s9, fy_s9;

	logic                     req_v_s10, oob_s10;
	side_idx_t                col_s10, row_s10;
	logic signed [WS_W-1:0]   fx_s10, fy_s10;
	logic signed [COORD_W-1:0] a00_s10 [0:1];
	logic signed [D_W-1:0]    d10_s10 [0:1];
	logic signed [D_W-1:0]    d01_s10 [0:1];
	logic signed [D11_W-1:0]  d11_s10 [0:1];

	logic                      req_v_s11, oob_s11;
	side_idx_t                 col_s11, row_s11;
	logic signed [WS_W-1:0]    fy_s11;
	logic signed [COORD_W-1:0] a00_s11 [0:1];
	logic signed [P1_W-1:0]    p10_s11 [0:1];
	logic signed [P1_W-1:0]    p01_s11 [0:1];
	logic signed [P11_W-1:0]   p11_s11 [0:1];

	logic                  req_v_s12, oob_s12;
	side_idx_t             col_s12, row_s12;
	logic [COORD_W-1:0]    psum_s12 [0:1];
	logic signed [PQ_W-1:0] pq_s12  [0:1];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_cols_q <= CFG_W'(2);
			src_rows_q <= CFG_W'(2);
			tgt_cols_q <= CFG_W'(2);
			tgt_rows_q <= CFG_W'(2);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SRC_COLS: src_cols_q <= clamp_side(cfg_data);
				CFG_SRC_ROWS: src_rows_q <= clamp_side(cfg_data);
				CFG_TGT_COLS: tgt_cols_q <= clamp_side(cfg_data);
				CFG_TGT_ROWS: tgt_rows_q <= clamp_side(cfg_data);
				default: ;
			endcase
		end
	end

	always_comb begin
		in_ctl.op    = opcode;
		in_ctl.wr_ok = (CFG_W'(grid_column) < src_cols_q) && (CFG_W'(grid_row) < src_rows_q);
		in_ctl.oob   = (CFG_W'(grid_column) >= tgt_cols_q) || (CFG_W'(grid_row) >= tgt_rows_q);
		in_ctl.col   = grid_column;
		in_ctl.row   = grid_row;
		in_ctl.x     = vertex_x;
		in_ctl.y     = vertex_y;
	end

	// hold the item beside the axis dividers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= LA; k++) begin
				ctl_v_s[k] <= 1'b0;
			end
		end else begin
			ctl_v_s[0] <= accept;
			for (int k = 1; k <= LA; k++) begin
				ctl_v_s[k] <= ctl_v_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		ctl_s[0] <= in_ctl;
		for (int k = 1; k <= LA; k++) begin
			ctl_s[k] <= ctl_s[k-1];
		end
	end

	vgbr_axis u_axis_col (
		.clk (clk),
		.pos (grid_column),
		.src (src_cols_q),
		.tgt (tgt_cols_q),
		.res (ax_col)
	);

	vgbr_axis u_axis_row (
		.clk (clk),
		.pos (grid_row),
		.src (src_rows_q),
		.tgt (tgt_rows_q),
		.res (ax_row)
	);

	// banks by row and column parity: the four corners always hit four banks
	assign wr_issue   = ctl_v_s[LA] && (ctl_s[LA].op == OP_WRITE) && ctl_s[LA].wr_ok;
	assign rd_issue   = ctl_v_s[LA] && (ctl_s[LA].op == OP_REQUEST) && !ctl_s[LA].oob;
	assign bank_waddr = {ctl_s[LA].row[SIDE_W-1:1], ctl_s[LA].col[SIDE_W-1:1]};
	assign bank_wdata = {ctl_s[LA].x, ctl_s[LA].y};

	always_comb begin
		side_idx_t c, r;
		logic [1:0] b2;
		for (int b = 0; b < NUM_BANKS; b++) begin
			b2 = 2'(b);
			c  = (ax_col.idx[0] == b2[0]) ? ax_col.idx : SIDE_W'(ax_col.idx + 1'b1);
			r  = (ax_row.idx[0] == b2[1]) ? ax_row.idx : SIDE_W'(ax_row.idx + 1'b1);
			bank_raddr[b] = {r[SIDE_W-1:1], c[SIDE_W-1:1]};
			bank_we[b]    = wr_issue && ({ctl_s[LA].row[0], ctl_s[LA].col[0]} == b2);
		end
	end

	for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
		vgbr_ram #(
			.WIDTH (VTX_W),
			.DEPTH (BANK_DEPTH)
		) u_bank (
			.clk   (clk),
			.we    (bank_we[b]),
			.waddr (bank_waddr),
			.wdata (bank_wdata),
			.re    (rd_issue),
			.raddr (bank_raddr[b]),
			.rdata (bank_rdata[b])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_v_s9  <= 1'b0;
			req_v_s10 <= 1'b0;
			req_v_s11 <= 1'b0;
			req_v_s12 <= 1'b0;
			done      <= 1'b0;
		end else begin
			req_v_s9  <= ctl_v_s[LA] && (ctl_s[LA].op == OP_REQUEST);
			req_v_s10 <= req_v_s9;
			req_v_s11 <= req_v_s10;
			req_v_s12 <= req_v_s11;
			done      <= req_v_s12;
		end
	end

	always_ff @(posedge clk) begin
		oob_s9 <= ctl_s[LA].oob;
		col_s9 <= ctl_s[LA].col;
		row_s9 <= ctl_s[LA].row;
		px_s9  <= ax_col.idx[0];
		py_s9  <= ax_row.idx[0];
		fx_s9  <= ax_col.weight;
		fy_s9  <= ax_row.weight;
	end

	// corner differences
	always_ff @(posedge clk) begin
		logic signed [COORD_W-1:0] a00, a10, a01, a11;
		logic [VTX_W-1:0] v00, v10, v01, v11;
		v00 = bank_rdata[{py_s9, px_s9}];
		v10 = bank_rdata[{py_s9, ~px_s9}];
		v01 = bank_rdata[{~py_s9, px_s9}];
		v11 = bank_rdata[{~py_s9, ~px_s9}];
		for (int g = 0; g < 2; g++) begin
			a00 = (g == 0) ? v00[VTX_W-1:COORD_W] : v00[COORD_W-1:0];
			a10 = (g == 0) ? v10[VTX_W-1:COORD_W] : v10[COORD_W-1:0];
			a01 = (g == 0) ? v01[VTX_W-1:COORD_W] : v01[COORD_W-1:0];
			a11 = (g == 0) ? v11[VTX_W-1:COORD_W] : v11[COORD_W-1:0];
			a00_s10[g] <= a00;
			d10_s10[g] <= D_W'(a10) - D_W'(a00);
			d01_s10[g] <= D_W'(a01) - D_W'(a00);
			d11_s10[g] <= D11_W'(a11) - D11_W'(a10) - D11_W'(a01) + D11_W'(a00);
		end
		oob_s10 <= oob_s9;
		col_s10 <= col_s9;
		row_s10 <= row_s9;
		fx_s10  <= $signed({1'b0, fx_s9});
		fy_s10  <= $signed({1'b0, fy_s9});
	end

	// weight products
	always_ff @(posedge clk) begin
		for (int g = 0; g < 2; g++) begin
			a00_s11[g] <= a00_s10[g];
			p10_s11[g] <= P1_W'(fx_s10) * P1_W'(d10_s10[g]);
			p01_s11[g] <= P1_W'(fy_s10) * P1_W'(d01_s10[g]);
			p11_s11[g] <= P11_W'(fx_s10) * P11_W'(d11_s10[g]);
		end
		oob_s11 <= oob_s10;
		col_s11 <= col_s10;
		row_s11 <= row_s10;
		fy_s11  <= fy_s10;
	end

	// floor shifts are upper slices of the signed products
	always_ff @(posedge clk) begin
		logic signed [T_W-1:0] t;
		for (int g = 0; g < 2; g++) begin
			t = p11_s11[g][P11_W-1:WEIGHT_BITS];
			pq_s12[g]   <= PQ_W'(fy_s11) * PQ_W'(t);
			psum_s12[g] <= a00_s11[g]
				+ p10_s11[g][WEIGHT_BITS+COORD_W-1:WEIGHT_BITS]
				+ p01_s11[g][WEIGHT_BITS+COORD_W-1:WEIGHT_BITS];
		end
		oob_s12 <= oob_s11;
		col_s12 <= col_s11;
		row_s12 <= row_s11;
	end

	always_ff @(posedge clk) begin
		out_column <= col_s12;
		out_row    <= row_s12;
		if (oob_s12) begin
			out_x  <= '0;
			out_y  <= '0;
			status <= STATUS_OUTSIDE;
		end else begin
			out_x  <= psum_s12[0] + pq_s12[0][WEIGHT_BITS+COORD_W-1:WEIGHT_BITS];
			out_y  <= psum_s12[1] + pq_s12[1][WEIGHT_BITS+COORD_W-1:WEIGHT_BITS];
			status <= STATUS_OK;
		end
	end

	`VGBR_ASSERT_ALWAYS(a_one_bank_write, clk, arst_n, $onehot0(bank_we))
	`VGBR_ASSERT_IMP(a_no_read_on_write, clk, arst_n, |bank_we, !rd_issue)
	`VGBR_ASSERT_IMP(a_req_result, clk, arst_n, accept && opcode == OP_REQUEST, ##(RESULT_LAT) done)
	`VGBR_ASSERT_IMP(a_wr_silent, clk, arst_n, accept && opcode == OP_WRITE, ##(RESULT_LAT) !done)

endmodule
